// ===== rtl/core/lrk_pkg.sv =====
// Shared types, codes and microprogram for the Lorenz RK4 stepper.
`timescale 1ns / 1ps

package lrk_pkg;

  localparam int WORD_W    = 48;
  localparam int FRAC_W    = 32;
  localparam int PROD_W    = 2 * WORD_W;
  localparam int DIV_W     = PROD_W - FRAC_W;
  localparam int H_W       = 47;
  localparam int CFG_IDX_W = 3;
  localparam int PC_W      = 7;
  localparam int UCODE_LEN = 74;

  typedef logic signed [WORD_W-1:0] word_t;
  typedef logic [4:0]               rsel_t;
  typedef logic [2:0]               op_t;
  typedef logic [PC_W-1:0]          pc_t;

  localparam word_t WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
  localparam word_t WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_SIGMA   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RHO     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BETA    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_START_X = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_START_Y = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_START_Z = 3'd6;

  localparam word_t          RST_SIGMA = 48'sd42949672960;
  localparam word_t          RST_RHO   = 48'sd120259084288;
  localparam word_t          RST_BETA  = 48'sd11453246123;
  localparam logic [H_W-1:0] RST_STEP  = 47'd42949673;
  localparam word_t          RST_START = 48'sd4294967296;

  // Operand and destination selects of the datapath.
  localparam rsel_t R_SIG = 5'd0;
  localparam rsel_t R_RHO = 5'd1;
  localparam rsel_t R_BET = 5'd2;
  localparam rsel_t R_H   = 5'd3;
  localparam rsel_t R_PX  = 5'd4;
  localparam rsel_t R_PY  = 5'd5;
  localparam rsel_t R_PZ  = 5'd6;
  localparam rsel_t R_QX  = 5'd7;
  localparam rsel_t R_QY  = 5'd8;
  localparam rsel_t R_QZ  = 5'd9;
  localparam rsel_t R_K1X = 5'd10;
  localparam rsel_t R_K1Y = 5'd11;
  localparam rsel_t R_K1Z = 5'd12;
  localparam rsel_t R_K2X = 5'd13;
  localparam rsel_t R_K2Y = 5'd14;
  localparam rsel_t R_K2Z = 5'd15;
  localparam rsel_t R_K3X = 5'd16;
  localparam rsel_t R_K3Y = 5'd17;
  localparam rsel_t R_K3Z = 5'd18;
  localparam rsel_t R_K4X = 5'd19;
  localparam rsel_t R_K4Y = 5'd20;
  localparam rsel_t R_K4Z = 5'd21;
  localparam rsel_t R_T0  = 5'd22;
  localparam rsel_t R_T1  = 5'd23;

  // Micro-operations.
  localparam op_t OP_MOV   = 3'd0;
  localparam op_t OP_ADD   = 3'd1;
  localparam op_t OP_SUB   = 3'd2;
  localparam op_t OP_MUL   = 3'd3;
  localparam op_t OP_MULH  = 3'd4;
  localparam op_t OP_MULD6 = 3'd5;

  typedef struct packed {
    op_t   op;
    rsel_t dst;
    rsel_t a;
    rsel_t b;
  } uop_t;

  typedef struct packed {
    logic load;
    logic restart;
    logic start;
    uop_t uop;
    logic capture;
  } ctrl_cmd_t;

  typedef struct packed {
    logic done;
  } dp_stat_t;

  function automatic uop_t mk(op_t op, rsel_t d, rsel_t a, rsel_t b);
    uop_t u;
    u.op  = op;
    u.dst = d;
    u.a   = a;
    u.b   = b;
    return u;
  endfunction

  // Derivative at q, written into the k group that starts at kx.
  function automatic uop_t deriv_uop(logic [2:0] s, rsel_t kx);
    uop_t u;
    case (s)
      3'd0: u = mk(OP_SUB, R_T0, R_QY, R_QX);
      3'd1: u = mk(OP_MUL, kx, R_SIG, R_T0);
      3'd2: u = mk(OP_SUB, R_T0, R_RHO, R_QZ);
      3'd3: u = mk(OP_MUL, R_T0, R_QX, R_T0);
      3'd4: u = mk(OP_SUB, rsel_t'(kx + 5'd1), R_T0, R_QY);
      3'd5: u = mk(OP_MUL, R_T0, R_QX, R_QY);
      3'd6: u = mk(OP_MUL, R_T1, R_BET, R_QZ);
      default: u = mk(OP_SUB, rsel_t'(kx + 5'd2), R_T0, R_T1);
    endcase
    return u;
  endfunction

  // q = p + h*k (halved for the middle stages).
  function automatic uop_t adv_uop(logic [2:0] s, rsel_t kx, op_t mop);
    rsel_t ax;
    uop_t  u;
    ax = rsel_t'(s[2:1]);
    if (!s[0]) begin
      u = mk(mop, R_T0, R_H, rsel_t'(kx + ax));
    end else begin
      u = mk(OP_ADD, rsel_t'(R_QX + ax), rsel_t'(R_PX + ax), R_T0);
    end
    return u;
  endfunction

  // Weighted sum, scale by h/6 and update of one axis.
  function automatic uop_t fin_uop(logic [2:0] s, rsel_t ax);
    uop_t u;
    case (s)
      3'd0: u = mk(OP_ADD, R_T0, rsel_t'(R_K2X + ax), rsel_t'(R_K2X + ax));
      3'd1: u = mk(OP_ADD, R_T0, rsel_t'(R_K1X + ax), R_T0);
      3'd2: u = mk(OP_ADD, R_T1, rsel_t'(R_K3X + ax), rsel_t'(R_K3X + ax));
      3'd3: u = mk(OP_ADD, R_T1, R_T1, rsel_t'(R_K4X + ax));
      3'd4: u = mk(OP_ADD, R_T0, R_T0, R_T1);
      3'd5: u = mk(OP_MULD6, R_T0, R_H, R_T0);
      default: u = mk(OP_ADD, rsel_t'(R_PX + ax), rsel_t'(R_PX + ax), R_T0);
    endcase
    return u;
  endfunction

  function automatic uop_t ucode(pc_t pc);
    pc_t  o;
    uop_t u;
    if (pc < 7'd3) begin
      u = mk(OP_MOV, rsel_t'(R_QX + 5'(pc)), rsel_t'(R_PX + 5'(pc)), R_PX);
    end else if (pc < 7'd11) begin
      o = pc - 7'd3;
      u = deriv_uop(o[2:0], R_K1X);
    end else if (pc < 7'd17) begin
      o = pc - 7'd11;
      u = adv_uop(o[2:0], R_K1X, OP_MULH);
    end else if (pc < 7'd25) begin
      o = pc - 7'd17;
      u = deriv_uop(o[2:0], R_K2X);
    end else if (pc < 7'd31) begin
      o = pc - 7'd25;
      u = adv_uop(o[2:0], R_K2X, OP_MULH);
    end else if (pc < 7'd39) begin
      o = pc - 7'd31;
      u = deriv_uop(o[2:0], R_K3X);
    end else if (pc < 7'd45) begin
      o = pc - 7'd39;
      u = adv_uop(o[2:0], R_K3X, OP_MUL);
    end else if (pc < 7'd53) begin
      o = pc - 7'd45;
      u = deriv_uop(o[2:0], R_K4X);
    end else if (pc < 7'd60) begin
      o = pc - 7'd53;
      u = fin_uop(o[2:0], 5'd0);
    end else if (pc < 7'd67) begin
      o = pc - 7'd60;
      u = fin_uop(o[2:0], 5'd1);
    end else begin
      o = pc - 7'd67;
      u = fin_uop(o[2:0], 5'd2);
    end
    return u;
  endfunction

endpackage

// ===== rtl/core/lrk_if.sv =====
// Item channel interfaces of the Lorenz RK4 stepper.
`timescale 1ns / 1ps

interface lrk_in_if;
  logic valid;
  logic ready;
  logic restart;
  modport source (output valid, output restart, input ready);
  modport sink (input valid, input restart, output ready);
endinterface

interface lrk_out_if;
  logic                 valid;
  logic                 ready;
  lrk_pkg::word_t       new_x;
  lrk_pkg::word_t       new_y;
  lrk_pkg::word_t       new_z;
  logic                 overflow;
  modport source (output valid, output new_x, output new_y, output new_z,
                  output overflow, input ready);
  modport sink (input valid, input new_x, input new_y, input new_z,
                input overflow, output ready);
endinterface

// ===== rtl/core/lrk_mul.sv =====
// Signed 48x48 multiplier, one 16-bit slice of b per cycle.
`timescale 1ns / 1ps

module lrk_mul (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  lrk_pkg::word_t               a,
  input  lrk_pkg::word_t               b,
  output logic                         done,
  output logic signed [lrk_pkg::PROD_W-1:0] prod
);
  import lrk_pkg::*;

  word_t                     a_r;
  word_t                     b_r;
  logic [1:0]                cnt;
  logic                      busy;
  logic signed [16:0]        chunk;
  logic signed [64:0]        pp;
  logic signed [PROD_W-1:0]  ppw;
  logic signed [PROD_W-1:0]  term;

  // Lower slices are unsigned, the top slice carries the sign of b.
  always_comb begin
    case (cnt)
      2'd0:    chunk = $signed({1'b0, b_r[15:0]});
      2'd1:    chunk = $signed({1'b0, b_r[31:16]});
      default: chunk = $signed({b_r[47], b_r[47:32]});
    endcase
    pp  = 65'(a_r) * 65'(chunk);
    ppw = PROD_W'(pp);
    case (cnt)
      2'd0:    term = ppw;
      2'd1:    term = ppw <<< 16;
      default: term = ppw <<< 32;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= 2'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        a_r  <= a;
        b_r  <= b;
        prod <= '0;
        cnt  <= 2'd0;
        busy <= 1'b1;
      end else if (busy) begin
        prod <= prod + term;
        cnt  <= cnt + 2'd1;
        if (cnt == 2'd2) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== rtl/core/lrk_div6.sv =====
// Signed divide by six, truncating toward zero, eight bits a cycle.
`timescale 1ns / 1ps

module lrk_div6 (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic signed [lrk_pkg::DIV_W-1:0]  val,
  output logic                              done,
  output logic signed [lrk_pkg::DIV_W-1:0]  quo
);
  import lrk_pkg::*;

  logic [DIV_W-1:0] work;
  logic [DIV_W-1:0] mag;
  logic [1:0]       rem;
  logic [2:0]       cnt;
  logic             busy;
  logic             neg;
  logic [5:0]       s1;
  logic [5:0]       s2;

  // One radix-16 digit of a divide by three: returns quotient digit and remainder.
  function automatic logic [5:0] step3(logic [1:0] r, logic [3:0] n);
    logic [5:0]  c;
    logic [10:0] p;
    logic [3:0]  q;
    logic [5:0]  rr;
    c  = {r, n};
    p  = 11'(c) * 11'd43;
    q  = p[10:7];
    rr = c - {1'b0, q, 1'b0} - {2'b00, q};
    return {q, rr[1:0]};
  endfunction

  // x/6 is (x/2)/3 for a magnitude, so the halving is a shift.
  assign mag = val[DIV_W-1] ? DIV_W'(-val) : DIV_W'(val);
  assign s1  = step3(rem, work[DIV_W-1 -: 4]);
  assign s2  = step3(s1[1:0], work[DIV_W-5 -: 4]);
  assign quo = neg ? -$signed(work) : $signed(work);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= 3'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        neg  <= val[DIV_W-1];
        work <= mag >> 1;
        rem  <= 2'd0;
        cnt  <= 3'd0;
        busy <= 1'b1;
      end else if (busy) begin
        work <= {work[DIV_W-9:0], s1[5:2], s2[5:2]};
        rem  <= s2[1:0];
        cnt  <= cnt + 3'd1;
        if (cnt == 3'd7) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== rtl/core/lrk_dp.sv =====
// Datapath: configuration, point and stage registers, saturating ALU, mul and div units.
`timescale 1ns / 1ps

module lrk_dp (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [lrk_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [lrk_pkg::WORD_W-1:0]      cfg_data,
  input  lrk_pkg::ctrl_cmd_t              cmd,
  output lrk_pkg::dp_stat_t               stat,
  output lrk_pkg::word_t                  out_x,
  output lrk_pkg::word_t                  out_y,
  output lrk_pkg::word_t                  out_z,
  output logic                            out_ovf
);
  import lrk_pkg::*;

  word_t          sigma, rho, beta, sx, sy, sz;
  logic [H_W-1:0] h;
  word_t          px, py, pz, qx, qy, qz;
  word_t          k1x, k1y, k1z, k2x, k2y, k2z, k3x, k3y, k3z, k4x, k4y, k4z;
  word_t          t0, t1;
  logic           ovf;
  op_t            op_r;
  rsel_t          dst_r;

  word_t                    a_val, b_val;
  logic                     is_alu, is_mul;
  logic                     mul_done, div_done;
  logic signed [PROD_W-1:0] prod, shifted;
  logic signed [DIV_W-1:0]  quo;
  logic                     wr_en, wr_ovf, done_next;
  rsel_t                    wr_dst;
  word_t                    wr_val;
  logic [WORD_W:0]          alu_r, mul_r, div_r;

  function automatic word_t pick(rsel_t r);
    word_t v;
    case (r)
      R_SIG: v = sigma;
      R_RHO: v = rho;
      R_BET: v = beta;
      R_H:   v = {1'b0, h};
      R_PX:  v = px;
      R_PY:  v = py;
      R_PZ:  v = pz;
      R_QX:  v = qx;
      R_QY:  v = qy;
      R_QZ:  v = qz;
      R_K1X: v = k1x;
      R_K1Y: v = k1y;
      R_K1Z: v = k1z;
      R_K2X: v = k2x;
      R_K2Y: v = k2y;
      R_K2Z: v = k2z;
      R_K3X: v = k3x;
      R_K3Y: v = k3y;
      R_K3Z: v = k3z;
      R_K4X: v = k4x;
      R_K4Y: v = k4y;
      R_K4Z: v = k4z;
      R_T0:  v = t0;
      R_T1:  v = t1;
      default: v = '0;
    endcase
    return v;
  endfunction

  // Clamp a wide signed value to the word; top bit of the result is the overflow flag.
  function automatic logic [WORD_W:0] sat_w(logic signed [PROD_W-1:0] v);
    logic ok;
    ok = (&v[PROD_W-1:WORD_W-1]) || !(|v[PROD_W-1:WORD_W-1]);
    if (ok) begin
      return {1'b0, v[WORD_W-1:0]};
    end
    return {1'b1, v[PROD_W-1] ? WORD_MIN : WORD_MAX};
  endfunction

  function automatic logic [WORD_W:0] sat_addsub(word_t a, word_t b, logic sub);
    logic [WORD_W:0] s;
    s = sub ? ({a[WORD_W-1], a} - {b[WORD_W-1], b}) : ({a[WORD_W-1], a} + {b[WORD_W-1], b});
    if (s[WORD_W] != s[WORD_W-1]) begin
      return {1'b1, s[WORD_W] ? WORD_MIN : WORD_MAX};
    end
    return {1'b0, s[WORD_W-1:0]};
  endfunction

  assign a_val  = pick(cmd.uop.a);
  assign b_val  = pick(cmd.uop.b);
  assign is_alu = cmd.uop.op inside {OP_MOV, OP_ADD, OP_SUB};
  assign is_mul = cmd.uop.op inside {OP_MUL, OP_MULH, OP_MULD6};

  lrk_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.start && is_mul),
    .a     (a_val),
    .b     (b_val),
    .done  (mul_done),
    .prod  (prod)
  );

  // h*k/2 drops one more fraction bit than a plain product.
  assign shifted = (op_r == OP_MULH) ? (prod >>> (FRAC_W + 1)) : (prod >>> FRAC_W);

  lrk_div6 u_div (
    .clk   (clk),
    .rst   (rst),
    .start (mul_done && (op_r == OP_MULD6)),
    .val   (shifted[DIV_W-1:0]),
    .done  (div_done),
    .quo   (quo)
  );

  always_comb begin
    if (cmd.uop.op == OP_MOV) begin
      alu_r = {1'b0, a_val};
    end else begin
      alu_r = sat_addsub(a_val, b_val, cmd.uop.op == OP_SUB);
    end
    mul_r = sat_w(shifted);
    div_r = sat_w(PROD_W'(quo));
    wr_en     = 1'b0;
    wr_dst    = cmd.uop.dst;
    wr_val    = alu_r[WORD_W-1:0];
    wr_ovf    = alu_r[WORD_W];
    if (cmd.start && is_alu) begin
      wr_en = 1'b1;
    end else if (mul_done && (op_r != OP_MULD6)) begin
      wr_en  = 1'b1;
      wr_dst = dst_r;
      wr_val = mul_r[WORD_W-1:0];
      wr_ovf = mul_r[WORD_W];
    end else if (div_done) begin
      wr_en  = 1'b1;
      wr_dst = dst_r;
      wr_val = div_r[WORD_W-1:0];
      wr_ovf = div_r[WORD_W];
    end
    done_next = wr_en;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sigma     <= RST_SIGMA;
      rho       <= RST_RHO;
      beta      <= RST_BETA;
      h         <= RST_STEP;
      sx        <= RST_START;
      sy        <= RST_START;
      sz        <= RST_START;
      px        <= RST_START;
      py        <= RST_START;
      pz        <= RST_START;
      ovf       <= 1'b0;
      stat.done <= 1'b0;
    end else begin
      stat.done <= done_next;
      if (cfg_we) begin
        case (cfg_index)
          CFG_SIGMA:   sigma <= cfg_data;
          CFG_RHO:     rho   <= cfg_data;
          CFG_BETA:    beta  <= cfg_data;
          CFG_STEP:    h     <= cfg_data[H_W-1:0];
          CFG_START_X: sx    <= cfg_data;
          CFG_START_Y: sy    <= cfg_data;
          CFG_START_Z: sz    <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.load) begin
        ovf <= 1'b0;
        if (cmd.restart) begin
          px <= sx;
          py <= sy;
          pz <= sz;
        end
      end else if (wr_en) begin
        if (wr_ovf) begin
          ovf <= 1'b1;
        end
        case (wr_dst)
          R_PX:  px  <= wr_val;
          R_PY:  py  <= wr_val;
          R_PZ:  pz  <= wr_val;
          R_QX:  qx  <= wr_val;
          R_QY:  qy  <= wr_val;
          R_QZ:  qz  <= wr_val;
          R_K1X: k1x <= wr_val;
          R_K1Y: k1y <= wr_val;
          R_K1Z: k1z <= wr_val;
          R_K2X: k2x <= wr_val;
          R_K2Y: k2y <= wr_val;
          R_K2Z: k2z <= wr_val;
          R_K3X: k3x <= wr_val;
          R_K3Y: k3y <= wr_val;
          R_K3Z: k3z <= wr_val;
          R_K4X: k4x <= wr_val;
          R_K4Y: k4y <= wr_val;
          R_K4Z: k4z <= wr_val;
          R_T0:  t0  <= wr_val;
          R_T1:  t1  <= wr_val;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      op_r  <= cmd.uop.op;
      dst_r <= cmd.uop.dst;
    end
    if (cmd.capture) begin
      out_x   <= px;
      out_y   <= py;
      out_z   <= pz;
      out_ovf <= ovf;
    end
  end

endmodule

// ===== rtl/core/lrk_ctrl.sv =====
// Controller: item handshake and sequencing of the RK4 microprogram.
`timescale 1ns / 1ps

module lrk_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_restart,
  output logic               in_ready,
  input  logic               out_ready,
  output logic               out_valid,
  output lrk_pkg::ctrl_cmd_t cmd,
  input  lrk_pkg::dp_stat_t  stat
);
  import lrk_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_ISSUE = 2'd1;
  localparam logic [1:0] S_WAIT  = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;
  localparam pc_t        PC_LAST = pc_t'(UCODE_LEN - 1);

  logic [1:0] state, state_next;
  pc_t        pc, pc_next;
  logic       out_valid_next;

  always_comb begin
    state_next  = state;
    pc_next     = pc;
    in_ready    = 1'b0;
    cmd         = '0;
    cmd.uop     = ucode(pc);
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load    = 1'b1;
          cmd.restart = in_restart;
          pc_next     = '0;
          state_next  = S_ISSUE;
        end
      end
      S_ISSUE: begin
        cmd.start  = 1'b1;
        state_next = S_WAIT;
      end
      S_WAIT: begin
        if (stat.done) begin
          if (pc == PC_LAST) begin
            state_next = S_DONE;
          end else begin
            pc_next    = pc + 7'd1;
            state_next = S_ISSUE;
          end
        end
      end
      S_DONE: begin
        // Hold the finished point until the output register is free.
        if (!out_valid || out_ready) begin
          cmd.capture = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
    if (cmd.capture) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      pc        <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      pc        <= pc_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

// ===== rtl/core/lorenz_rk4_step.sv =====
// Top level of the Lorenz RK4 stepper.
//
//   channel   dir   payload                          handshake
//   req       in    restart                          valid/ready
//   rsp       out   new_x, new_y, new_z, overflow    valid/ready
//   cfg       in    cfg_index, cfg_data              cfg_we, no wait
//
// One item runs a 74-step microprogram; its run time is set by the
// 28 products through the shared 16-bit-slice multiplier and the three
// divide-by-six passes.
// Synchronous reset loads the default coefficients and start point.
// A finished result waits in the output register; the next item is taken
// as soon as that result has moved there.
`timescale 1ns / 1ps

module lorenz_rk4_step (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [lrk_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lrk_pkg::WORD_W-1:0]    cfg_data,
  lrk_in_if.sink                        req,
  lrk_out_if.source                     rsp
);
  import lrk_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  lrk_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (req.valid),
    .in_restart (req.restart),
    .in_ready   (req.ready),
    .out_ready  (rsp.ready),
    .out_valid  (rsp.valid),
    .cmd        (cmd),
    .stat       (stat)
  );

  lrk_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_x     (rsp.new_x),
    .out_y     (rsp.new_y),
    .out_z     (rsp.new_z),
    .out_ovf   (rsp.overflow)
  );

endmodule
